// ----- sv/htfp_pkg.sv -----
package htfp_pkg;

  localparam int BYTE_W  = 8;
  localparam int INDEX_W = 4;
  localparam int LEN_W   = 5;

  localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hB3;
  localparam logic [BYTE_W-1:0] CR_BYTE  = 8'h0D;
  localparam logic [BYTE_W-1:0] LF_BYTE  = 8'h0A;

endpackage

// ----- sv/htfp_store.sv -----
module htfp_store #(
  parameter int PAYLOAD_MAX = 16,
  parameter int AW          = 4
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [htfp_pkg::BYTE_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [htfp_pkg::BYTE_W-1:0] rdata
);
  import htfp_pkg::*;

  logic [BYTE_W-1:0] mem [PAYLOAD_MAX];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/htfp_ctrl.sv -----
module htfp_ctrl #(
  parameter int PAYLOAD_MAX = 16,
  parameter int AW          = 4,
  parameter int CW          = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [htfp_pkg::BYTE_W-1:0]  rx_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [htfp_pkg::BYTE_W-1:0]  payload_byte,
  output logic [htfp_pkg::INDEX_W-1:0] byte_index,
  output logic [htfp_pkg::LEN_W-1:0]   frame_length,
  output logic                         is_last,
  output logic                         mem_we,
  output logic [AW-1:0]                mem_waddr,
  output logic [htfp_pkg::BYTE_W-1:0]  mem_wdata,
  output logic                         mem_re,
  output logic [AW-1:0]                mem_raddr,
  input  logic [htfp_pkg::BYTE_W-1:0]  mem_rdata
);
  import htfp_pkg::*;

  typedef enum logic [2:0] {
    ST_HUNT1,
    ST_HUNT2,
    ST_COLLECT,
    ST_WAIT_LF,
    ST_EMIT
  } state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic          ovf;
  logic [CW-1:0] len;
  logic [CW-1:0] idx;
  logic          pend;
  logic [CW-1:0] pend_idx;
  logic          pend_last;

  logic in_fire;
  logic out_free;
  logic issue;
  logic load_empty;
  logic has_room;
  logic emit_last;

  assign in_ready   = (state != ST_EMIT);
  assign in_fire    = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  // one read in flight at a time; the output register is free when its data lands
  assign issue      = (state == ST_EMIT) && !pend && out_free;
  assign load_empty = issue && (len == '0);
  assign has_room   = (count < CW'(PAYLOAD_MAX));
  assign emit_last  = ((idx + CW'(1)) == len);

  assign mem_we    = in_fire && (state == ST_COLLECT) && (rx_byte != CR_BYTE) && has_room;
  assign mem_waddr = count[AW-1:0];
  assign mem_wdata = rx_byte;
  assign mem_re    = issue && (len != '0);
  assign mem_raddr = idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_HUNT1;
      count     <= '0;
      ovf       <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pend) begin
        out_valid    <= 1'b1;
        payload_byte <= mem_rdata;
        byte_index   <= INDEX_W'(pend_idx);
        frame_length <= LEN_W'(len);
        is_last      <= pend_last;
        pend         <= 1'b0;
      end else if (load_empty) begin
        // empty frame: a single zero transaction marked last
        out_valid    <= 1'b1;
        payload_byte <= '0;
        byte_index   <= '0;
        frame_length <= '0;
        is_last      <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_HUNT1: begin
          if (in_fire && rx_byte == HDR_BYTE) begin
            state <= ST_HUNT2;
          end
        end
        ST_HUNT2: begin
          if (in_fire && rx_byte == HDR_BYTE) begin
            state <= ST_COLLECT;
          end
        end
        ST_COLLECT: begin
          if (in_fire) begin
            if (rx_byte == CR_BYTE) begin
              state <= ST_WAIT_LF;
            end else if (has_room) begin
              count <= count + CW'(1);
            end else begin
              ovf <= 1'b1;
            end
          end
        end
        ST_WAIT_LF: begin
          if (in_fire) begin
            if (rx_byte == LF_BYTE && !ovf) begin
              len   <= count;
              idx   <= '0;
              state <= ST_EMIT;
            end else begin
              state <= ST_HUNT1;
            end
            count <= '0;
            ovf   <= 1'b0;
          end
        end
        ST_EMIT: begin
          if (issue) begin
            if (len == '0) begin
              state <= ST_HUNT1;
            end else begin
              pend      <= 1'b1;
              pend_idx  <= idx;
              pend_last <= emit_last;
              idx       <= idx + CW'(1);
              if (emit_last) begin
                state <= ST_HUNT1;
              end
            end
          end
        end
        default: begin
          state <= ST_HUNT1;
        end
      endcase
    end
  end

endmodule

// ----- sv/header_trailer_frame_parser_top.sv -----
// Frame parser for a serial byte stream: hunts for the header 0xB3 0xB3, stores
// up to PAYLOAD_MAX payload bytes in an on-chip buffer until 0x0D, and on a
// following 0x0A emits the payload as one transaction per byte (index, frame
// length, last mark), or a single zero transaction for an empty frame. Frames
// with a bad trailer or more than PAYLOAD_MAX payload bytes are dropped. A new
// input byte is accepted every cycle while a frame is being received. After an
// accepted frame the input is held off while the buffer is read out: reads are
// registered with a single read in flight, so a payload byte is read only after
// the last one has landed in the output register and that register is free; an
// output stall holds the readout. The last result can still wait in the output
// register while the next frame is received.
module header_trailer_frame_parser_top #(
  parameter int PAYLOAD_MAX = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [htfp_pkg::BYTE_W-1:0]  rx_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [htfp_pkg::BYTE_W-1:0]  payload_byte,
  output logic [htfp_pkg::INDEX_W-1:0] byte_index,
  output logic [htfp_pkg::LEN_W-1:0]   frame_length,
  output logic                         is_last
);
  import htfp_pkg::*;

  localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
  localparam int CW = $clog2(PAYLOAD_MAX + 1);

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;

  htfp_ctrl #(
    .PAYLOAD_MAX(PAYLOAD_MAX),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .payload_byte(payload_byte),
    .byte_index  (byte_index),
    .frame_length(frame_length),
    .is_last     (is_last),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  htfp_store #(
    .PAYLOAD_MAX(PAYLOAD_MAX),
    .AW         (AW)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule

// ----- dv/frame_result_checker.sv -----
module frame_result_checker #(
  parameter int PAYLOAD_MAX = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [htfp_pkg::BYTE_W-1:0]  rx_byte,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [htfp_pkg::BYTE_W-1:0]  payload_byte,
  input  logic [htfp_pkg::INDEX_W-1:0] byte_index,
  input  logic [htfp_pkg::LEN_W-1:0]   frame_length,
  input  logic                         is_last,
  output int                           mismatch_count,
  output int                           results_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import htfp_pkg::*;

  typedef enum logic [1:0] {
    HUNT_FIRST,
    HUNT_SECOND,
    COLLECT,
    WAIT_LF
  } parse_phase_e;

  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    logic [INDEX_W-1:0] index;
    logic [LEN_W-1:0]   length;
    logic               last;
  } frame_result_t;

  frame_result_t     expected_results[$];
  parse_phase_e      phase = HUNT_FIRST;
  int unsigned       stored = 0;
  logic [BYTE_W-1:0] payload_copy [PAYLOAD_MAX];
  logic              overflowed = 1'b0;
  int                mismatches = 0;
  int                pending = 0;

  assign mismatch_count  = mismatches;
  assign results_pending = pending;

  task automatic report(input string what);
    $display("%0t ns: frame result mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic parse_rx_byte(input logic [BYTE_W-1:0] b);
    frame_result_t r;
    case (phase)
      HUNT_FIRST: begin
        if (b == HDR_BYTE) phase = HUNT_SECOND;
      end
      HUNT_SECOND: begin
        if (b == HDR_BYTE) phase = COLLECT;
      end
      COLLECT: begin
        if (b == CR_BYTE) begin
          phase = WAIT_LF;
        end else if (stored < PAYLOAD_MAX) begin
          payload_copy[stored] = b;
          stored++;
        end else begin
          overflowed = 1'b1;
        end
      end
      default: begin
        if (b == LF_BYTE && !overflowed) begin
          if (stored == 0) begin
            r = '0;
            r.last = 1'b1;
            expected_results.push_back(r);
          end else begin
            for (int i = 0; i < stored; i++) begin
              r.data   = payload_copy[i];
              r.index  = INDEX_W'(i);
              r.length = LEN_W'(stored);
              r.last   = (i == stored - 1);
              expected_results.push_back(r);
            end
          end
        end
        // accepted or dropped, the frame ends here
        phase      = HUNT_FIRST;
        stored     = 0;
        overflowed = 1'b0;
      end
    endcase
  endtask

  task automatic check_result();
    frame_result_t want;
    string         diffs;
    if (expected_results.size() == 0) begin
      report($sformatf("unexpected transaction byte=%h index=%0d length=%0d last=%b",
                       payload_byte, byte_index, frame_length, is_last));
    end else begin
      want  = expected_results.pop_front();
      diffs = "";
      if (payload_byte !== want.data)
        diffs = {diffs, $sformatf(" payload_byte got %h want %h", payload_byte, want.data)};
      if (byte_index !== want.index)
        diffs = {diffs, $sformatf(" byte_index got %0d want %0d", byte_index, want.index)};
      if (frame_length !== want.length)
        diffs = {diffs, $sformatf(" frame_length got %0d want %0d", frame_length,
                                  want.length)};
      if (is_last !== want.last)
        diffs = {diffs, $sformatf(" is_last got %b want %b", is_last, want.last)};
      if (diffs != "") report(diffs);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_results.delete();
      phase      = HUNT_FIRST;
      stored     = 0;
      overflowed = 1'b0;
    end else begin
      if (in_valid && in_ready) parse_rx_byte(rx_byte);
      if (out_valid && out_ready) check_result();
    end
    pending <= expected_results.size();
  end

endmodule

// ----- dv/header_trailer_frame_parser_top_tb.sv -----
module header_trailer_frame_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import htfp_pkg::*;

  localparam int PAYLOAD_MAX = 16;
  localparam int RX_BYTES    = 350;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 2 * PAYLOAD_MAX + 20;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [BYTE_W-1:0]   rx_byte = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [BYTE_W-1:0]   payload_byte;
  logic [INDEX_W-1:0]  byte_index;
  logic [LEN_W-1:0]    frame_length;
  logic                is_last;

  int                  mismatch_count;
  int                  results_pending;
  int                  burst_left = 0;
  int                  bytes_sent = 0;
  int                  frame_no = 0;
  int                  frame_kind;
  int                  frame_len;
  int unsigned         cycle_count = 0;
  logic [15:0]         ready_pattern = '1;
  int                  pattern_age = 0;
  int                  pattern_pos = 0;

  always #10 clk = ~clk;

  header_trailer_frame_parser_top #(
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .payload_byte (payload_byte),
    .byte_index   (byte_index),
    .frame_length (frame_length),
    .is_last      (is_last)
  );

  frame_result_checker #(
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) frame_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .payload_byte    (payload_byte),
    .byte_index      (byte_index),
    .frame_length    (frame_length),
    .is_last         (is_last),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: pick a new stall pattern every so often, all-ready among them
  always @(posedge clk) begin
    if (pattern_age == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pattern <= '1;
        1: ready_pattern <= 16'($urandom);
        2: ready_pattern <= 16'($urandom | $urandom);
        default: ready_pattern <= 16'($urandom & $urandom);
      endcase
      pattern_age <= $urandom_range(16, 80);
    end else begin
      pattern_age <= pattern_age - 1;
    end
    out_ready   <= ready_pattern[pattern_pos];
    pattern_pos <= (pattern_pos + 1) % 16;
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  function automatic logic [BYTE_W-1:0] random_payload();
    logic [BYTE_W-1:0] b;
    if ($urandom_range(0, 7) == 0) return HDR_BYTE;
    do b = BYTE_W'($urandom); while (b == CR_BYTE);
    return b;
  endfunction

  task automatic send_frame(input int len, input logic [BYTE_W-1:0] trailer);
    send_byte(HDR_BYTE);
    send_byte(HDR_BYTE);
    for (int i = 0; i < len; i++) send_byte(random_payload());
    send_byte(CR_BYTE);
    send_byte(trailer);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // noise outside a frame, then an empty frame with a stray byte between headers
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HDR_BYTE);
    send_byte(8'h55);
    send_byte(HDR_BYTE);
    send_byte(CR_BYTE);
    send_byte(LF_BYTE);
    // extreme bytes and a header byte inside the payload
    send_byte(HDR_BYTE);
    send_byte(HDR_BYTE);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HDR_BYTE);
    send_byte(CR_BYTE);
    send_byte(LF_BYTE);
    // bad trailers: CR after CR, and a wrong byte after an empty payload
    send_byte(HDR_BYTE);
    send_byte(HDR_BYTE);
    send_byte(8'h41);
    send_byte(CR_BYTE);
    send_byte(CR_BYTE);
    send_byte(HDR_BYTE);
    send_byte(HDR_BYTE);
    send_byte(CR_BYTE);
    send_byte(8'h0B);

    while (bytes_sent < RX_BYTES) begin
      frame_kind = $urandom_range(0, 19);
      if (frame_no % 8 == 3)
        frame_len = PAYLOAD_MAX;
      else if ($urandom_range(0, 3) == 0)
        frame_len = $urandom_range(7, PAYLOAD_MAX);
      else
        frame_len = $urandom_range(0, 6);
      if (frame_kind < 13) begin
        send_frame(frame_len, LF_BYTE);
      end else if (frame_kind < 15) begin
        send_frame(PAYLOAD_MAX + $urandom_range(1, 4), LF_BYTE);
      end else if (frame_kind < 17) begin
        send_frame(frame_len, ($urandom_range(0, 1) == 0) ? CR_BYTE : BYTE_W'($urandom));
      end else if (frame_kind < 18) begin
        // truncated header followed by junk
        send_byte(HDR_BYTE);
        send_byte(BYTE_W'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom));
      end
      frame_no++;
    end
    in_valid <= 1'b0;

    // let the checker register the last transaction before waiting on it
    repeat (2) @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/htfp_pkg.sv
sv/htfp_store.sv
sv/htfp_ctrl.sv
sv/header_trailer_frame_parser_top.sv
dv/frame_result_checker.sv
dv/header_trailer_frame_parser_top_tb.sv
